>>> design/cnsc_pkg.sv
// Shared types, constants and helper functions of the natural-order string comparator.
package cnsc_pkg;

  localparam int MAX_LEN = 256;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int CW      = $clog2(MAX_LEN + 1);

  typedef logic [63:0] u64_t;

  localparam u64_t SAT_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam u64_t MUL10_LIMIT  = SAT_MAX / 10;
  localparam u64_t ARABIC_LIMIT = 64'd922337203685477580;
  localparam logic [15:0] CJK_FLOOR = 16'h3000;

  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPARE       = 2'd2;

  localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
  localparam logic [1:0] VERDICT_LESS      = 2'd1;
  localparam logic [1:0] VERDICT_GREATER   = 2'd2;

  // Numeral values 10 to 14 are the unit characters.
  localparam logic [3:0] VAL_TEN      = 4'd10;
  localparam logic [3:0] VAL_HUNDRED  = 4'd11;
  localparam logic [3:0] VAL_THOUSAND = 4'd12;
  localparam logic [3:0] VAL_MYRIAD   = 4'd13;
  localparam logic [3:0] VAL_YI       = 4'd14;

  typedef enum logic [2:0] {
    CAT_PLAIN   = 3'd0,
    CAT_DIGIT   = 3'd1,
    CAT_NUMERAL = 3'd2,
    CAT_STEM    = 3'd3,
    CAT_BRANCH  = 3'd4,
    CAT_PART    = 3'd5
  } cat_t;

  typedef struct packed {
    cat_t       cat;
    logic [3:0] val;
  } glyph_t;

  typedef struct packed {
    logic clr;
    logic step;
    logic fin;
    logic arabic;
    logic single;
    logic [3:0] val;
  } lane_cmd_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic clear;
    logic init;
    logic begin_run;
    logic adv;
    logic step;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic pre_undecided;
    logic cls_match;
    logic fold_eq;
    logic next_end;
    logic pos_end;
    logic in_a;
    logic in_b;
    logic busy;
    logic val_ne;
    logic val_lt;
    logic same;
  } dp_stat_t;

  function automatic glyph_t classify(input logic [15:0] c);
    glyph_t g;
    g = '{CAT_PLAIN, 4'd0};
    if (c >= 16'h0030 && c <= 16'h0039) begin
      g = '{CAT_DIGIT, c[3:0]};
    end else if (c >= CJK_FLOOR) begin
      case (c)
        16'h7532: g = '{CAT_STEM, 4'd1};
        16'h4E59: g = '{CAT_STEM, 4'd2};
        16'h4E19: g = '{CAT_STEM, 4'd3};
        16'h4E01: g = '{CAT_STEM, 4'd4};
        16'h620A: g = '{CAT_STEM, 4'd5};
        16'h5DF1: g = '{CAT_STEM, 4'd6};
        16'h5E9A: g = '{CAT_STEM, 4'd7};
        16'h8F9B: g = '{CAT_STEM, 4'd8};
        16'h58EC: g = '{CAT_STEM, 4'd9};
        16'h7678: g = '{CAT_STEM, 4'd10};
        16'h5B50: g = '{CAT_BRANCH, 4'd1};
        16'h4E11: g = '{CAT_BRANCH, 4'd2};
        16'h5BC5: g = '{CAT_BRANCH, 4'd3};
        16'h536F: g = '{CAT_BRANCH, 4'd4};
        16'h8FB0: g = '{CAT_BRANCH, 4'd5};
        16'h5DF3: g = '{CAT_BRANCH, 4'd6};
        16'h5348: g = '{CAT_BRANCH, 4'd7};
        16'h672A: g = '{CAT_BRANCH, 4'd8};
        16'h7533: g = '{CAT_BRANCH, 4'd9};
        16'h9149: g = '{CAT_BRANCH, 4'd10};
        16'h620C: g = '{CAT_BRANCH, 4'd11};
        16'h4EA5: g = '{CAT_BRANCH, 4'd12};
        16'h4E0A: g = '{CAT_PART, 4'd1};
        16'h4E2D: g = '{CAT_PART, 4'd2};
        16'h4E0B: g = '{CAT_PART, 4'd3};
        16'h3007, 16'h96F6: g = '{CAT_NUMERAL, 4'd0};
        16'h4E00, 16'h58F9: g = '{CAT_NUMERAL, 4'd1};
        16'h4E8C, 16'h4E24, 16'h8D30: g = '{CAT_NUMERAL, 4'd2};
        16'h4E09, 16'h53C1: g = '{CAT_NUMERAL, 4'd3};
        16'h56DB, 16'h8086: g = '{CAT_NUMERAL, 4'd4};
        16'h4E94, 16'h4F0D: g = '{CAT_NUMERAL, 4'd5};
        16'h516D, 16'h9646: g = '{CAT_NUMERAL, 4'd6};
        16'h4E03, 16'h67D2: g = '{CAT_NUMERAL, 4'd7};
        16'h516B, 16'h634C: g = '{CAT_NUMERAL, 4'd8};
        16'h4E5D, 16'h7396: g = '{CAT_NUMERAL, 4'd9};
        16'h5341, 16'h62FE: g = '{CAT_NUMERAL, VAL_TEN};
        16'h767E, 16'h4F70: g = '{CAT_NUMERAL, VAL_HUNDRED};
        16'h5343, 16'h4EDF: g = '{CAT_NUMERAL, VAL_THOUSAND};
        16'h4E07, 16'h842C: g = '{CAT_NUMERAL, VAL_MYRIAD};
        16'h4EBF, 16'h5104: g = '{CAT_NUMERAL, VAL_YI};
        default: g = '{CAT_PLAIN, 4'd0};
      endcase
    end
    return g;
  endfunction

  function automatic logic [15:0] fold(input logic [15:0] c);
    return (c >= 16'h0041 && c <= 16'h005A) ? c + 16'd32 : c;
  endfunction

  // Both operands are at most SAT_MAX, so the raw sum cannot wrap.
  function automatic u64_t sat_add(input u64_t a, input u64_t b);
    u64_t s;
    s = a + b;
    return s[63] ? SAT_MAX : s;
  endfunction

endpackage

>>> design/cnsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cnsc_lane.sv
// Number accumulator for one string: digit runs, numeral runs and table positions.
module cnsc_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cnsc_pkg::lane_cmd_t    cmd,
  output logic                   busy,
  output cnsc_pkg::u64_t         value
);

  cnsc_pkg::u64_t temp_r, section_r, total_r, prod_r, val_r;
  cnsc_pkg::u64_t t1, operand, prod_x10, apply_sum;
  logic [3:0] n_r, op_r, nsteps;
  logic       busy_r;

  // A unit character with nothing before it counts as one of that unit.
  assign t1 = (temp_r == '0) ? 64'd1 : temp_r;

  always_comb begin
    operand = temp_r;
    nsteps  = 4'd1;
    case (cmd.val)
      cnsc_pkg::VAL_TEN, cnsc_pkg::VAL_HUNDRED, cnsc_pkg::VAL_THOUSAND: begin
        operand = t1;
        nsteps  = cmd.val - 4'd9;
      end
      cnsc_pkg::VAL_MYRIAD: begin
        operand = cnsc_pkg::sat_add(section_r, t1);
        nsteps  = 4'd4;
      end
      cnsc_pkg::VAL_YI: begin
        operand = cnsc_pkg::sat_add(cnsc_pkg::sat_add(total_r, section_r), t1);
        nsteps  = 4'd8;
      end
      default: begin
        operand = temp_r;
        nsteps  = 4'd1;
      end
    endcase
  end

  assign prod_x10 = (prod_r > cnsc_pkg::MUL10_LIMIT) ? cnsc_pkg::SAT_MAX
                                                     : (prod_r << 3) + (prod_r << 1);

  always_comb begin
    case (op_r)
      cnsc_pkg::VAL_TEN, cnsc_pkg::VAL_HUNDRED, cnsc_pkg::VAL_THOUSAND:
        apply_sum = cnsc_pkg::sat_add(section_r, prod_r);
      cnsc_pkg::VAL_MYRIAD:
        apply_sum = cnsc_pkg::sat_add(total_r, prod_r);
      default:
        apply_sum = cnsc_pkg::sat_add(prod_r, {60'd0, op_r});
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r    <= '0;
    end else if (cmd.clr) begin
      temp_r    <= '0;
      section_r <= '0;
      total_r   <= '0;
      busy_r    <= 1'b0;
    end else if (cmd.step) begin
      if (cmd.single) begin
        temp_r <= {60'd0, cmd.val};
      end else if (!(cmd.arabic && temp_r >= cnsc_pkg::ARABIC_LIMIT)) begin
        prod_r <= operand;
        n_r    <= nsteps;
        op_r   <= cmd.val;
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (n_r != '0) begin
        prod_r <= prod_x10;
        n_r    <= n_r - 4'd1;
      end else begin
        busy_r <= 1'b0;
        case (op_r)
          cnsc_pkg::VAL_TEN, cnsc_pkg::VAL_HUNDRED, cnsc_pkg::VAL_THOUSAND: begin
            section_r <= apply_sum;
            temp_r    <= '0;
          end
          cnsc_pkg::VAL_MYRIAD: begin
            total_r   <= apply_sum;
            section_r <= '0;
            temp_r    <= '0;
          end
          cnsc_pkg::VAL_YI: begin
            total_r   <= prod_r;
            section_r <= '0;
            temp_r    <= '0;
          end
          default: temp_r <= apply_sum;
        endcase
      end
    end
    if (cmd.fin) begin
      val_r <= cnsc_pkg::sat_add(cnsc_pkg::sat_add(total_r, section_r), temp_r);
    end
  end

  assign busy  = busy_r;
  assign value = val_r;

endmodule

>>> design/cnsc_datapath.sv
// Datapath: string buffers, fill counts, walk positions and the two number lanes.
module cnsc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        code_unit,
  input  cnsc_pkg::dp_cmd_t  cmd,
  output cnsc_pkg::dp_stat_t stat
);

  logic [cnsc_pkg::CW-1:0] cnt_a_r, cnt_b_r, pa_r, pb_r, pa_inc, pb_inc;
  logic                    ovf_r, first_r, same_r;
  cnsc_pkg::cat_t          run_cat_r;
  logic [15:0]             qa, qb;
  cnsc_pkg::glyph_t        ga, gb;
  logic                    full_a, full_b, single, in_a, in_b;
  cnsc_pkg::lane_cmd_t     lcmd_a, lcmd_b;
  logic                    busy_a, busy_b;
  cnsc_pkg::u64_t          val_a, val_b;

  assign full_a = (cnt_a_r == cnsc_pkg::CW'(cnsc_pkg::MAX_LEN));
  assign full_b = (cnt_b_r == cnsc_pkg::CW'(cnsc_pkg::MAX_LEN));

  cnsc_ram #(.WIDTH(16), .DEPTH(cnsc_pkg::MAX_LEN)) u_ram_a (
    .clk(clk), .we(cmd.load_a && !full_a), .waddr(cnt_a_r[cnsc_pkg::AW-1:0]),
    .wdata(code_unit), .raddr(pa_r[cnsc_pkg::AW-1:0]), .rdata(qa)
  );

  cnsc_ram #(.WIDTH(16), .DEPTH(cnsc_pkg::MAX_LEN)) u_ram_b (
    .clk(clk), .we(cmd.load_b && !full_b), .waddr(cnt_b_r[cnsc_pkg::AW-1:0]),
    .wdata(code_unit), .raddr(pb_r[cnsc_pkg::AW-1:0]), .rdata(qb)
  );

  assign ga     = cnsc_pkg::classify(qa);
  assign gb     = cnsc_pkg::classify(qb);
  assign pa_inc = pa_r + 1'b1;
  assign pb_inc = pb_r + 1'b1;
  assign single = (run_cat_r == cnsc_pkg::CAT_STEM) || (run_cat_r == cnsc_pkg::CAT_BRANCH) ||
                  (run_cat_r == cnsc_pkg::CAT_PART);
  assign in_a   = (pa_r < cnt_a_r) && (ga.cat == run_cat_r) && (first_r || !single);
  assign in_b   = (pb_r < cnt_b_r) && (gb.cat == run_cat_r) && (first_r || !single);

  always_comb begin
    lcmd_a.clr    = cmd.begin_run;
    lcmd_a.step   = cmd.step && in_a;
    lcmd_a.fin    = cmd.fin;
    lcmd_a.arabic = (run_cat_r == cnsc_pkg::CAT_DIGIT);
    lcmd_a.single = single;
    lcmd_a.val    = ga.val;
    lcmd_b        = lcmd_a;
    lcmd_b.step   = cmd.step && in_b;
    lcmd_b.val    = gb.val;
  end

  cnsc_lane u_lane_a (.clk(clk), .rst_n(rst_n), .cmd(lcmd_a), .busy(busy_a), .value(val_a));
  cnsc_lane u_lane_b (.clk(clk), .rst_n(rst_n), .cmd(lcmd_b), .busy(busy_b), .value(val_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.clear) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.load_a) begin
        if (full_a) ovf_r <= 1'b1;
        else cnt_a_r <= cnt_a_r + 1'b1;
      end
      if (cmd.load_b) begin
        if (full_b) ovf_r <= 1'b1;
        else cnt_b_r <= cnt_b_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      pa_r <= '0;
      pb_r <= '0;
    end else if (cmd.adv) begin
      pa_r <= pa_inc;
      pb_r <= pb_inc;
    end else if (cmd.step) begin
      if (in_a) pa_r <= pa_inc;
      if (in_b) pb_r <= pb_inc;
    end
    if (cmd.begin_run) begin
      run_cat_r <= ga.cat;
      first_r   <= 1'b1;
      same_r    <= 1'b1;
    end else if (cmd.step) begin
      first_r <= 1'b0;
      // Equal values only continue the walk when the two runs are the same text.
      if ((in_a != in_b) || (in_a && qa != qb)) same_r <= 1'b0;
    end
  end

  always_comb begin
    stat.pre_undecided = ovf_r || (cnt_a_r == '0) || (cnt_b_r == '0);
    stat.cls_match     = (ga.cat == gb.cat) && (ga.cat != cnsc_pkg::CAT_PLAIN);
    stat.fold_eq       = (cnsc_pkg::fold(qa) == cnsc_pkg::fold(qb));
    stat.next_end      = (pa_inc >= cnt_a_r) || (pb_inc >= cnt_b_r);
    stat.pos_end       = (pa_r >= cnt_a_r) || (pb_r >= cnt_b_r);
    stat.in_a          = in_a;
    stat.in_b          = in_b;
    stat.busy          = busy_a || busy_b;
    stat.val_ne        = (val_a != val_b);
    stat.val_lt        = (val_a < val_b);
    stat.same          = same_r;
  end

endmodule

>>> design/cnsc_controller.sv
// Controller: request handshakes and the state machine that sequences the walk.
module cnsc_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_cmd,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [1:0]         out_verdict,
  output cnsc_pkg::dp_cmd_t  dp_cmd,
  input  cnsc_pkg::dp_stat_t dp_stat
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_FETCH = 7'b000_0010,
    ST_CLASS = 7'b000_0100,
    ST_RSTEP = 7'b000_1000,
    ST_RWAIT = 7'b001_0000,
    ST_CMPV  = 7'b010_0000,
    ST_OUT   = 7'b100_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] verdict_r, verdict_nxt;
  logic       accept;

  assign in_tready   = (state_r == ST_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign out_tvalid  = (state_r == ST_OUT);
  assign out_verdict = verdict_r;

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    dp_cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            cnsc_pkg::CMD_APPEND_FIRST:  dp_cmd.load_a = 1'b1;
            cnsc_pkg::CMD_APPEND_SECOND: dp_cmd.load_b = 1'b1;
            cnsc_pkg::CMD_COMPARE: begin
              verdict_nxt = cnsc_pkg::VERDICT_UNDECIDED;
              if (dp_stat.pre_undecided) begin
                state_nxt = ST_OUT;
              end else begin
                dp_cmd.init = 1'b1;
                state_nxt   = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_CLASS;
      ST_CLASS: begin
        if (dp_stat.cls_match) begin
          dp_cmd.begin_run = 1'b1;
          state_nxt        = ST_RSTEP;
        end else if (!dp_stat.fold_eq || dp_stat.next_end) begin
          state_nxt = ST_OUT;
        end else begin
          dp_cmd.adv = 1'b1;
          state_nxt  = ST_FETCH;
        end
      end
      ST_RSTEP: begin
        if (!dp_stat.in_a && !dp_stat.in_b) begin
          dp_cmd.fin = 1'b1;
          state_nxt  = ST_CMPV;
        end else begin
          dp_cmd.step = 1'b1;
          state_nxt   = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (!dp_stat.busy) state_nxt = ST_RSTEP;
      end
      ST_CMPV: begin
        if (dp_stat.val_ne) begin
          verdict_nxt = dp_stat.val_lt ? cnsc_pkg::VERDICT_LESS : cnsc_pkg::VERDICT_GREATER;
          state_nxt   = ST_OUT;
        end else if (!dp_stat.same || dp_stat.pos_end) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_CLASS;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          dp_cmd.clear = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      verdict_r <= cnsc_pkg::VERDICT_UNDECIDED;
    end else begin
      state_r   <= state_nxt;
      verdict_r <= verdict_nxt;
    end
  end

endmodule

>>> design/chinese_natural_string_compare.sv
// Top level of the natural-order string comparator with Chinese numeral support.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | slave     | in_tvalid/in_tready  | in_tdata: code unit; in_tuser: command
//   out_    | master    | out_tvalid/out_tready| out_tdata: verdict
//
// An append request leaves the controller idle, so appends can follow back to back.
// A compare request walks both buffers: each plain unit passes through the fetch
// and class states, and each digit, numeral, stem, branch or part mark unit is
// stepped into the number lane of its string, with the walk waiting while a lane
// does its times-ten steps. The buffer RAMs have a registered read.
// Reset (rst_n low at a clock edge) empties both strings; buffer contents stay.
// While a result waits for out_tready, no new request is accepted.
//
// The two strings live in two RAMs. The controller walks them with separate
// read positions; runs of digits or numerals are fed unit by unit into one
// number lane per string, and their values are compared once both runs end.
// Any case the rules cannot settle yields the undecided verdict.
module chinese_natural_string_compare (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] verdict, [7:2] zero
);

  cnsc_pkg::dp_cmd_t  dp_cmd;
  cnsc_pkg::dp_stat_t dp_stat;
  logic [1:0]         verdict;

  cnsc_controller u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_cmd(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_verdict(verdict),
    .dp_cmd(dp_cmd), .dp_stat(dp_stat)
  );

  cnsc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .code_unit(in_tdata), .cmd(dp_cmd), .stat(dp_stat)
  );

  assign out_tdata = {6'd0, verdict};

endmodule

>>> design/cnsc_checker.sv
// Port-level checks of the comparator, bound to the top level.
module cnsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request accepted while a result waits");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] <= cnsc_pkg::VERDICT_GREATER) && (out_tdata[7:2] == 6'd0))
    else $error("verdict code out of range");

  a_compare_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == cnsc_pkg::CMD_COMPARE |=> !in_tready)
    else $error("ready right after a compare request");

endmodule

bind chinese_natural_string_compare cnsc_checker u_cnsc_checker (.*);

>>> bench/tb_top.sv
// Self-checking testbench for the natural-order string comparator.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] code_unit
  logic [1:0]  in_tuser;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [1:0] verdict, [7:2] zero

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Predictor state: the two strings as the block holds them.
  logic [15:0] str_a[$];
  logic [15:0] str_b[$];
  bit          str_overflow;

  // Verdicts still owed by the block, oldest first.
  logic [1:0]  pending_verdicts[$];
  int          mismatch_count;
  int          cycle_count;
  bit          idle_enable;
  bit          hold_receiver;

  // Code units used to build interesting strings.
  logic [15:0] hanzi_numerals[] = '{16'h3007, 16'h96F6, 16'h4E00, 16'h58F9, 16'h4E8C,
    16'h4E24, 16'h8D30, 16'h4E09, 16'h53C1, 16'h56DB, 16'h8086, 16'h4E94, 16'h4F0D,
    16'h516D, 16'h9646, 16'h4E03, 16'h67D2, 16'h516B, 16'h634C, 16'h4E5D, 16'h7396,
    16'h5341, 16'h62FE, 16'h767E, 16'h4F70, 16'h5343, 16'h4EDF, 16'h4E07, 16'h842C,
    16'h4EBF, 16'h5104};
  logic [15:0] cyclic_signs[] = '{16'h7532, 16'h4E59, 16'h4E19, 16'h4E01, 16'h620A,
    16'h5DF1, 16'h5E9A, 16'h8F9B, 16'h58EC, 16'h7678, 16'h5B50, 16'h4E11, 16'h5BC5,
    16'h536F, 16'h8FB0, 16'h5DF3, 16'h5348, 16'h672A, 16'h7533, 16'h9149, 16'h620C,
    16'h4EA5, 16'h4E0A, 16'h4E2D, 16'h4E0B};

  chinese_natural_string_compare i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Classifies one unit into its category and its table or digit value.
  function automatic cnsc_pkg::glyph_t unit_class(input logic [15:0] c);
    cnsc_pkg::glyph_t g;
    g.cat = cnsc_pkg::CAT_PLAIN;
    g.val = 4'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      g.cat = cnsc_pkg::CAT_DIGIT;
      g.val = 4'(c - 16'h0030);
    end else if (c >= cnsc_pkg::CJK_FLOOR) begin
      foreach (hanzi_numerals[k]) if (hanzi_numerals[k] == c) begin
        g.cat = cnsc_pkg::CAT_NUMERAL;
        // Table order groups the variants; map index to value.
        case (k)
          0, 1:        g.val = 4'd0;
          2, 3:        g.val = 4'd1;
          4, 5, 6:     g.val = 4'd2;
          7, 8:        g.val = 4'd3;
          9, 10:       g.val = 4'd4;
          11, 12:      g.val = 4'd5;
          13, 14:      g.val = 4'd6;
          15, 16:      g.val = 4'd7;
          17, 18:      g.val = 4'd8;
          19, 20:      g.val = 4'd9;
          21, 22:      g.val = cnsc_pkg::VAL_TEN;
          23, 24:      g.val = cnsc_pkg::VAL_HUNDRED;
          25, 26:      g.val = cnsc_pkg::VAL_THOUSAND;
          27, 28:      g.val = cnsc_pkg::VAL_MYRIAD;
          default:     g.val = cnsc_pkg::VAL_YI;
        endcase
      end
      foreach (cyclic_signs[k]) if (cyclic_signs[k] == c) begin
        if (k < 10) begin
          g.cat = cnsc_pkg::CAT_STEM;
          g.val = 4'(k + 1);
        end else if (k < 22) begin
          g.cat = cnsc_pkg::CAT_BRANCH;
          g.val = 4'(k - 9);
        end else begin
          g.cat = cnsc_pkg::CAT_PART;
          g.val = 4'(k - 21);
        end
      end
    end
    return g;
  endfunction

  function automatic cnsc_pkg::u64_t clamp_sum(input cnsc_pkg::u64_t a,
                                               input cnsc_pkg::u64_t b);
    cnsc_pkg::u64_t s;
    s = a + b;
    return (s > cnsc_pkg::SAT_MAX) ? cnsc_pkg::SAT_MAX : s;
  endfunction

  function automatic cnsc_pkg::u64_t clamp_product(input cnsc_pkg::u64_t a,
                                                   input cnsc_pkg::u64_t k);
    if (k != 0 && a > cnsc_pkg::SAT_MAX / k) return cnsc_pkg::SAT_MAX;
    return a * k;
  endfunction

  function automatic logic [15:0] lower_ascii(input logic [15:0] c);
    return (c >= 16'h0041 && c <= 16'h005A) ? c + 16'd32 : c;
  endfunction

  // Reads the number run starting at pos in s; returns its value and length.
  function automatic cnsc_pkg::u64_t run_value(input logic [15:0] s[$], input int pos,
                                               input bit arabic, output int len);
    cnsc_pkg::u64_t total, section, temp, v;
    int k;
    cnsc_pkg::glyph_t g;
    total = 0; section = 0; temp = 0; v = 0;
    k = pos;
    while (k < s.size()) begin
      g = unit_class(s[k]);
      if (arabic) begin
        if (g.cat != cnsc_pkg::CAT_DIGIT) break;
        if (v < cnsc_pkg::ARABIC_LIMIT) v = v * 10 + 64'(g.val);
      end else begin
        if (g.cat != cnsc_pkg::CAT_NUMERAL) break;
        if (g.val < 10) begin
          temp = clamp_sum(clamp_product(temp, 10), 64'(g.val));
        end else begin
          if (temp == 0) temp = 1;
          case (g.val)
            cnsc_pkg::VAL_TEN:
              section = clamp_sum(section, clamp_product(temp, 10));
            cnsc_pkg::VAL_HUNDRED:
              section = clamp_sum(section, clamp_product(temp, 100));
            cnsc_pkg::VAL_THOUSAND:
              section = clamp_sum(section, clamp_product(temp, 1000));
            cnsc_pkg::VAL_MYRIAD: begin
              total = clamp_sum(total, clamp_product(clamp_sum(section, temp), 10000));
              section = 0;
            end
            default: begin
              total = clamp_product(clamp_sum(clamp_sum(total, section), temp), 100000000);
              section = 0;
            end
          endcase
          temp = 0;
        end
      end
      k++;
    end
    len = k - pos;
    return arabic ? v : clamp_sum(clamp_sum(total, section), temp);
  endfunction

  // Natural-order verdict of the two strings held now.
  function automatic logic [1:0] natural_verdict();
    int i, j, l1, l2;
    cnsc_pkg::glyph_t g1, g2;
    cnsc_pkg::u64_t a, b;
    i = 0; j = 0;
    if (str_overflow || str_a.size() == 0 || str_b.size() == 0)
      return cnsc_pkg::VERDICT_UNDECIDED;
    while (i < str_a.size() && j < str_b.size()) begin
      g1 = unit_class(str_a[i]);
      g2 = unit_class(str_b[j]);
      if (g1.cat == g2.cat && g1.cat != cnsc_pkg::CAT_PLAIN) begin
        l1 = 1; l2 = 1;
        if (g1.cat == cnsc_pkg::CAT_DIGIT || g1.cat == cnsc_pkg::CAT_NUMERAL) begin
          a = run_value(str_a, i, g1.cat == cnsc_pkg::CAT_DIGIT, l1);
          b = run_value(str_b, j, g1.cat == cnsc_pkg::CAT_DIGIT, l2);
        end else begin
          a = 64'(g1.val);
          b = 64'(g2.val);
        end
        if (a != b) return (a < b) ? cnsc_pkg::VERDICT_LESS : cnsc_pkg::VERDICT_GREATER;
        // Equal values only continue when the text is identical.
        if (l1 != l2) return cnsc_pkg::VERDICT_UNDECIDED;
        for (int k = 0; k < l1; k++)
          if (str_a[i + k] != str_b[j + k]) return cnsc_pkg::VERDICT_UNDECIDED;
        i += l1;
        j += l2;
      end else begin
        if (lower_ascii(str_a[i]) != lower_ascii(str_b[j]))
          return cnsc_pkg::VERDICT_UNDECIDED;
        i++;
        j++;
      end
    end
    return cnsc_pkg::VERDICT_UNDECIDED;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Offers one request, idling at random first, and updates the predictor on accept.
  // The request stays valid afterwards so that requests can follow back to back.
  task automatic send_request(input logic [1:0] cmd, input logic [15:0] unit);
    if (idle_enable) begin
      while ($urandom_range(99) < 13) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= unit;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (cmd)
      cnsc_pkg::CMD_APPEND_FIRST: begin
        if (str_a.size() < cnsc_pkg::MAX_LEN) str_a.push_back(unit);
        else str_overflow = 1'b1;
      end
      cnsc_pkg::CMD_APPEND_SECOND: begin
        if (str_b.size() < cnsc_pkg::MAX_LEN) str_b.push_back(unit);
        else str_overflow = 1'b1;
      end
      cnsc_pkg::CMD_COMPARE: begin
        pending_verdicts.push_back(natural_verdict());
        str_a.delete();
        str_b.delete();
        str_overflow = 1'b0;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Withdraws the request valid before the sender pauses.
  task automatic release_input();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_pair(input logic [15:0] a[$], input logic [15:0] b[$]);
    foreach (a[k]) send_request(cnsc_pkg::CMD_APPEND_FIRST, a[k]);
    foreach (b[k]) send_request(cnsc_pkg::CMD_APPEND_SECOND, b[k]);
    send_request(cnsc_pkg::CMD_COMPARE, 16'($urandom));
  endtask

  // Picks one unit from a mix weighted toward the interesting categories.
  function automatic logic [15:0] pick_unit();
    case ($urandom_range(5))
      0: return 16'(16'h0030 + $urandom_range(9));
      1: return hanzi_numerals[$urandom_range(hanzi_numerals.size() - 1)];
      2: return cyclic_signs[$urandom_range(cyclic_signs.size() - 1)];
      3: return 16'(16'h0041 + $urandom_range(57));
      4: return 16'($urandom_range(16'hFFFF));
      default: return 16'(16'h0030 + $urandom_range(9));
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] a[$], b[$];
    // Digit runs by value: 9 before 10.
    a = '{16'h0039}; b = '{16'h0031, 16'h0030};
    load_pair(a, b);
    // Chinese numerals: twelve thousand versus one hundred million.
    a = '{16'h4E00, 16'h4E07, 16'h4E8C, 16'h5343}; b = '{16'h4E00, 16'h4EBF};
    load_pair(a, b);
    // Stems and part marks by table position.
    a = '{16'h4E0B}; b = '{16'h4E0A};
    load_pair(a, b);
    a = '{16'h7678}; b = '{16'h7532};
    load_pair(a, b);
    // Case folding passes, then the branch decides.
    a = '{16'h0041, 16'h4EA5}; b = '{16'h0061, 16'h5B50};
    load_pair(a, b);
    // Equal values with different text is undecided.
    a = '{16'h0030, 16'h0037}; b = '{16'h0037};
    load_pair(a, b);
    // Empty first string.
    a = {}; b = '{16'hFFFF};
    load_pair(a, b);
    // Saturating runs of numerals and digits.
    a = {}; b = {};
    repeat (25) begin
      a.push_back(16'h0039);
      b.push_back(16'h4E5D);
    end
    a.push_back(16'h4E0A);
    load_pair(a, a);
    b.push_back(16'h5104);
    load_pair(b, b);
    // The unused command changes nothing.
    send_request(CMD_UNUSED, 16'hFFFF);
    send_request(CMD_UNUSED, 16'h0000);
  endtask

  task automatic test_overflow();
    // Fill the first string past its end; the compare must then be undecided.
    repeat (cnsc_pkg::MAX_LEN + 2) send_request(cnsc_pkg::CMD_APPEND_FIRST, 16'h0035);
    send_request(cnsc_pkg::CMD_APPEND_SECOND, 16'h0035);
    send_request(cnsc_pkg::CMD_COMPARE, 16'h0000);
    repeat (cnsc_pkg::MAX_LEN) send_request(cnsc_pkg::CMD_APPEND_SECOND, 16'h4E07);
    send_request(cnsc_pkg::CMD_APPEND_FIRST, 16'h4E07);
    send_request(cnsc_pkg::CMD_COMPARE, 16'hFFFF);
  endtask

  // Mostly related string pairs that share a prefix, so walks reach deep.
  task automatic test_random(input int budget);
    logic [15:0] a[$], b[$], u;
    int sent, n;
    sent = 0;
    while (sent < budget) begin
      a = {}; b = {};
      n = $urandom_range(6);
      repeat (n) begin
        u = pick_unit();
        a.push_back(u);
        b.push_back(($urandom_range(9) == 0) ? lower_ascii(u) : u);
      end
      repeat ($urandom_range(3)) a.push_back(pick_unit());
      repeat ($urandom_range(3)) b.push_back(pick_unit());
      if ($urandom_range(19) == 0) a = {};
      if ($urandom_range(19) == 0) send_request(CMD_UNUSED, 16'($urandom));
      load_pair(a, b);
      sent += a.size() + b.size() + 1;
    end
  endtask

  // The receiver holds off while the sender keeps going, then the sender drains.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      test_random(40);
      begin
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
    join
    release_input();
    wait (pending_verdicts.size() == 0);
    test_random(20);
  endtask

  // Receiver: random stalls, or a long hold, driven at the falling edge.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_receiver) out_tready <= 1'b0;
      else if (idle_enable) out_tready <= ($urandom_range(99) >= 13);
      else out_tready <= 1'b1;
    end
  end

  // Result check: each accepted verdict against the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with no compare pending", out_tdata));
      end else begin
        if (out_tdata[1:0] !== pending_verdicts[0])
          report_mismatch($sformatf("verdict %0d, expected %0d", out_tdata[1:0],
                                    pending_verdicts[0]));
        if (out_tdata[7:2] !== 6'd0) report_mismatch("nonzero padding in out_tdata");
        void'(pending_verdicts.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("chinese_natural_string_compare regression: fail");
    $finish;
  end

  initial begin
    int drain;
    mismatch_count = 0;
    idle_enable = 1'b1;
    hold_receiver = 1'b0;
    str_overflow = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_UNUSED;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(100);
    // A stretch with no idling on either side.
    idle_enable = 1'b0;
    test_random(80);
    idle_enable = 1'b1;
    test_random(60);
    release_input();
    wait (pending_verdicts.size() == 0);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0) begin
      $display("chinese_natural_string_compare regression: pass");
    end else begin
      $display("chinese_natural_string_compare regression: fail");
    end
    $finish;
  end

endmodule

>>> chinese_natural_string_compare.f
design/cnsc_pkg.sv
design/cnsc_ram.sv
design/cnsc_lane.sv
design/cnsc_datapath.sv
design/cnsc_controller.sv
design/chinese_natural_string_compare.sv
design/cnsc_checker.sv
bench/tb_top.sv
